/* design/tlnv_pkg.sv */
// Shared types and constants for the text line-number and visible-character filter.
// No dependencies; used by the top level, front end and back end by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tlnv_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_ALL      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_NONBLANK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINT   = 3'd5;

	// characters
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_CTRL_END = 8'd32;
	localparam logic [7:0] CH_DEL      = 8'd127;
	localparam logic [7:0] CH_HIGH_END = 8'd160;
	localparam logic [7:0] CARET_OFS   = 8'd64;

	typedef struct packed {
		logic number_all;
		logic number_nonblank;
		logic squeeze_blank;
		logic show_ends;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

	// shape of the rendered byte itself
	typedef enum logic [1:0] {
		BODY_RAW,    // ch
		BODY_CARET,  // '^' ch
		BODY_DOLLAR, // '$' LF
		BODY_META    // 'M' '-' '^' ch
	} body_kind_t;

	typedef struct packed {
		logic       num;
		body_kind_t kind;
		logic [7:0] ch;
	} desc_t;

endpackage

`default_nettype wire

/* design/text_line_number_visible_filter.sv */
// Text line-number and visible-character filter, top level.
//
// Input channel: in_valid / in_stall with in_byte and new_file, one text byte per item.
// Output channel: out_valid / out_stall with out_byte and last_of_run, one rendered byte
// per item; last_of_run marks the final byte caused by an input item.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data (bit 0); cfg_ready is
// always high. Write only while the block is idle.
// Each input item yields 0 to NUMBER_DIGITS+5 output bytes (11 with six digits): the line
// number and a tab, then one, two or four bytes for the character itself. A squeezed blank
// line yields nothing.
// The front end takes one item per cycle while the item queue (QUEUE_DEPTH entries) has
// room; the back end sends one output byte per cycle while out_stall is low, so sustained
// throughput is one item per cycle only for single-byte items; an item of N bytes holds
// the back end for N output bytes. An accepted item is written into the queue and its
// first byte then into the output register. When the receiver stalls the output register
// holds its byte; the queue fills and then in_stall rises. Reset clears the configuration,
// empties the queue, sets the line counter to 1 and starts at the beginning of a line.
`timescale 1ns / 1ps
`default_nettype none

module text_line_number_visible_filter #(
	parameter int NUMBER_DIGITS = 6,
	parameter int QUEUE_DEPTH   = 4
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [7:0]                     in_byte,
	input  wire logic                           new_file,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [7:0]                          out_byte,
	output logic                                last_of_run,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tlnv_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic                           cfg_data
);

	localparam int DW = $bits(tlnv_pkg::desc_t);
	localparam int QW = DW + 8 * NUMBER_DIGITS;

	logic                       push_valid;
	logic                       push_ready;
	tlnv_pkg::desc_t            push_desc;
	logic [8*NUMBER_DIGITS-1:0] push_digits;
	logic                       pop;
	logic                       head_valid;
	logic [QW-1:0]              head_data;
	tlnv_pkg::desc_t            head_desc;

	assign head_desc = tlnv_pkg::desc_t'(head_data[QW-1 -: DW]);

	tlnv_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.new_file   (new_file),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.push_digits(push_digits)
	);

	tlnv_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid && push_ready),
		.push_ready(push_ready),
		.push_data ({push_desc, push_digits}),
		.pop       (pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	tlnv_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_desc  (head_desc),
		.head_digits(head_data[8*NUMBER_DIGITS-1:0]),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

endmodule

`default_nettype wire

/* design/tlnv_front.sv */
// Front end: configuration registers, line state, squeeze decision and item classification.
// Depends on tlnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlnv_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [7:0]                         in_byte,
	input  wire logic                               new_file,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [tlnv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic                               cfg_data,
	output logic                                    push_valid,
	input  wire logic                               push_ready,
	output tlnv_pkg::desc_t                         push_desc,
	output logic [8*NUMBER_DIGITS-1:0]              push_digits
);

	localparam int BW = 4 * NUMBER_DIGITS;

	tlnv_pkg::cfg_t cfg_q;
	logic           prev_nl_q;
	logic [1:0]     blank_q;
	logic [BW-1:0]  line_q;

	logic          accept;
	logic          nl;
	logic          drop;
	logic [1:0]    cnt_base;
	logic [1:0]    cnt_next;
	logic [BW-1:0] line_inc;
	logic [NUMBER_DIGITS:0] carry;
	logic [NUMBER_DIGITS:0] blank;

	assign cfg_ready = 1'b1;
	assign in_stall  = !push_ready;
	assign accept    = in_valid && push_ready;

	always_comb begin
		nl       = (in_byte == tlnv_pkg::CH_LF);
		cnt_base = new_file ? 2'd0 : blank_q;
		drop     = 1'b0;
		cnt_next = 2'd0;
		if (cfg_q.squeeze_blank && nl && prev_nl_q) begin
			cnt_next = (cnt_base == 2'd3) ? 2'd3 : cnt_base + 2'd1;
			drop     = (cnt_next > 2'd1);
		end

		push_valid     = in_valid && !drop;
		push_desc.num  = prev_nl_q && !drop &&
			(cfg_q.number_nonblank ? !nl : cfg_q.number_all);

		push_desc.kind = tlnv_pkg::BODY_RAW;
		push_desc.ch   = in_byte;
		if (in_byte == tlnv_pkg::CH_TAB && cfg_q.show_tabs) begin
			push_desc.kind = tlnv_pkg::BODY_CARET;
			push_desc.ch   = tlnv_pkg::CH_I;
		end else if (nl && cfg_q.show_ends) begin
			push_desc.kind = tlnv_pkg::BODY_DOLLAR;
		end else if (cfg_q.show_nonprinting && in_byte < tlnv_pkg::CH_CTRL_END && !nl &&
				in_byte != tlnv_pkg::CH_TAB) begin
			push_desc.kind = tlnv_pkg::BODY_CARET;
			push_desc.ch   = in_byte + tlnv_pkg::CARET_OFS;
		end else if (cfg_q.show_nonprinting && in_byte == tlnv_pkg::CH_DEL) begin
			push_desc.kind = tlnv_pkg::BODY_CARET;
			push_desc.ch   = tlnv_pkg::CH_QMARK;
		end else if (cfg_q.show_nonprinting && in_byte > tlnv_pkg::CH_DEL &&
				in_byte < tlnv_pkg::CH_HIGH_END) begin
			push_desc.kind = tlnv_pkg::BODY_META;
			push_desc.ch   = in_byte - tlnv_pkg::CARET_OFS;
		end
	end

	// BCD increment: a digit steps when every digit below it is 9; all nines holds
	always_comb begin
		carry[0] = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			carry[i+1] = carry[i] && (line_q[4*i +: 4] == 4'd9);
		end
		line_inc = line_q;
		if (!carry[NUMBER_DIGITS]) begin
			for (int i = 0; i < NUMBER_DIGITS; i++) begin
				if (carry[i]) begin
					line_inc[4*i +: 4] = (line_q[4*i +: 4] == 4'd9) ? 4'd0
						: line_q[4*i +: 4] + 4'd1;
				end
			end
		end
	end

	// leading zeros print as spaces, units digit always printed
	always_comb begin
		blank[NUMBER_DIGITS] = 1'b1;
		for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
			blank[i] = blank[i+1] && (line_q[4*i +: 4] == 4'd0) && (i != 0);
			push_digits[8*i +: 8] = blank[i] ? tlnv_pkg::CH_SPACE
				: tlnv_pkg::CH_ZERO + {4'd0, line_q[4*i +: 4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q     <= '0;
			prev_nl_q <= 1'b1;
			blank_q   <= 2'd0;
			line_q    <= BW'(1);
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					tlnv_pkg::CFG_NUMBER_ALL:      cfg_q.number_all       <= cfg_data;
					tlnv_pkg::CFG_NUMBER_NONBLANK: cfg_q.number_nonblank  <= cfg_data;
					tlnv_pkg::CFG_SQUEEZE_BLANK:   cfg_q.squeeze_blank    <= cfg_data;
					tlnv_pkg::CFG_SHOW_ENDS:       cfg_q.show_ends        <= cfg_data;
					tlnv_pkg::CFG_SHOW_TABS:       cfg_q.show_tabs        <= cfg_data;
					tlnv_pkg::CFG_SHOW_NONPRINT:   cfg_q.show_nonprinting <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				blank_q <= cnt_next;
				if (!drop) prev_nl_q <= nl;
				if (push_desc.num) line_q <= line_inc;
			end
		end
	end

endmodule

`default_nettype wire

/* design/tlnv_queue.sv */
// Short register queue between front and back ends; one entry per item that produces output.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tlnv_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	output logic              push_ready,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic              head_valid,
	output logic [W-1:0]      head_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign push_ready = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)  rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

/* design/tlnv_back.sv */
// Back end: walks the queued item byte by byte (number prefix, tab, rendered byte)
// into the output register. Depends on tlnv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlnv_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      head_valid,
	input  wire tlnv_pkg::desc_t           head_desc,
	input  wire logic [8*NUMBER_DIGITS-1:0] head_digits,
	output logic                           pop,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [7:0]                     out_byte,
	output logic                           last_of_run
);

	localparam int PW = $clog2(NUMBER_DIGITS + 5);

	logic [PW-1:0] pos_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          last_q;

	logic          load;
	logic          last;
	logic [PW-1:0] prefix;
	logic [PW-1:0] body_len;
	logic [PW-1:0] bdiff;
	logic [1:0]    bpos;
	logic [7:0]    dbyte;
	logic [7:0]    body_byte;
	logic [7:0]    sel_byte;

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;

	assign load = !out_valid_q || !out_stall;

	always_comb begin
		prefix = head_desc.num ? PW'(NUMBER_DIGITS + 1) : '0;
		case (head_desc.kind)
			tlnv_pkg::BODY_RAW:  body_len = PW'(1);
			tlnv_pkg::BODY_META: body_len = PW'(4);
			default:             body_len = PW'(2);
		endcase
		bdiff = pos_q - prefix;
		bpos  = bdiff[1:0];
		last  = (pos_q == prefix + body_len - PW'(1));
		pop   = head_valid && load && last;

		// most significant digit goes first
		dbyte = tlnv_pkg::CH_SPACE;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (pos_q == PW'(NUMBER_DIGITS - 1 - i)) dbyte = head_digits[8*i +: 8];
		end

		case (head_desc.kind)
			tlnv_pkg::BODY_CARET:
				body_byte = (bpos == 2'd0) ? tlnv_pkg::CH_CARET : head_desc.ch;
			tlnv_pkg::BODY_DOLLAR:
				body_byte = (bpos == 2'd0) ? tlnv_pkg::CH_DOLLAR : tlnv_pkg::CH_LF;
			tlnv_pkg::BODY_META: begin
				case (bpos)
					2'd0:    body_byte = tlnv_pkg::CH_M;
					2'd1:    body_byte = tlnv_pkg::CH_DASH;
					2'd2:    body_byte = tlnv_pkg::CH_CARET;
					default: body_byte = head_desc.ch;
				endcase
			end
			default: body_byte = head_desc.ch;
		endcase

		if (head_desc.num && pos_q < PW'(NUMBER_DIGITS)) sel_byte = dbyte;
		else if (head_desc.num && pos_q == PW'(NUMBER_DIGITS)) sel_byte = tlnv_pkg::CH_TAB;
		else sel_byte = body_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= head_valid;
			if (head_valid) pos_q <= last ? '0 : pos_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			out_byte_q <= sel_byte;
			last_q     <= last;
		end
	end

	// part-way through an item the queue head must still be there
	a_mid_item_head: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != '0 |-> head_valid)
		else $error("byte position set with empty queue");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> pos_q < prefix + body_len)
		else $error("byte position past end of item");

	a_pop_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> pos_q == '0)
		else $error("position not rewound after last byte");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid_q && last_q)
		else $error("final byte of item not flagged");

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for text_line_number_visible_filter: directed and random text
// bytes under many filter settings, each rendered byte checked against an in-bench predictor.
// Depends on tlnv_pkg and the block's top level only.
`timescale 1ns / 1ps

module tb;

	localparam int DIGITS     = 6;
	localparam int TAIL       = 24;    // cycles waited after the scoreboard drains
	localparam int IDLE_LIMIT = 1000;  // cycles without any handshake before giving up
	localparam int RAND_ITEMS = 36;    // per random phase

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} rendered_t;

	class filter_scoreboard;
		tlnv_pkg::cfg_t      cfg;
		bit                  at_line_start;
		bit [1:0]            blank_run;
		bit [4*DIGITS-1:0]   line_bcd;
		rendered_t           expected_q[$];
		int                  errors, checked, accepted, squeezed, numbered;

		function new();
			cfg           = '0;
			at_line_start = 1'b1;
			blank_run     = '0;
			line_bcd      = 1;
		endfunction

		function void write_reg(logic [tlnv_pkg::CFG_IDX_W-1:0] idx, logic v);
			case (idx)
				tlnv_pkg::CFG_NUMBER_ALL:      cfg.number_all       = v;
				tlnv_pkg::CFG_NUMBER_NONBLANK: cfg.number_nonblank  = v;
				tlnv_pkg::CFG_SQUEEZE_BLANK:   cfg.squeeze_blank    = v;
				tlnv_pkg::CFG_SHOW_ENDS:       cfg.show_ends        = v;
				tlnv_pkg::CFG_SHOW_TABS:       cfg.show_tabs        = v;
				tlnv_pkg::CFG_SHOW_NONPRINT:   cfg.show_nonprinting = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// renders one text byte and queues the bytes it should produce
		function void note_input(logic [7:0] c, logic nf);
			logic [7:0] burst[$];
			logic       nl, lead, all_nines, num;
			logic [3:0] d;
			nl = (c == tlnv_pkg::CH_LF);
			accepted++;
			if (nf)
				blank_run = '0;
			if (cfg.squeeze_blank && nl && at_line_start) begin
				if (blank_run < 3)
					blank_run++;
				if (blank_run > 1) begin
					squeezed++;
					return;
				end
			end else begin
				blank_run = '0;
			end

			if (at_line_start) begin
				num = cfg.number_nonblank ? !nl : cfg.number_all;
				if (num) begin
					numbered++;
					lead = 1'b1;
					for (int i = DIGITS - 1; i >= 0; i--) begin
						d = line_bcd[4*i +: 4];
						if (d != 0 || i == 0)
							lead = 1'b0;
						burst.push_back(lead ? tlnv_pkg::CH_SPACE
							: tlnv_pkg::CH_ZERO + 8'(d));
					end
					burst.push_back(tlnv_pkg::CH_TAB);
					// BCD count, stuck once every digit is nine
					all_nines = 1'b1;
					for (int i = 0; i < DIGITS; i++)
						if (line_bcd[4*i +: 4] != 4'd9)
							all_nines = 1'b0;
					if (!all_nines) begin
						for (int i = 0; i < DIGITS; i++) begin
							if (line_bcd[4*i +: 4] == 4'd9) begin
								line_bcd[4*i +: 4] = 4'd0;
							end else begin
								line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
								break;
							end
						end
					end
				end
			end

			if (c == tlnv_pkg::CH_TAB && cfg.show_tabs) begin
				burst.push_back(tlnv_pkg::CH_CARET);
				burst.push_back(tlnv_pkg::CH_I);
			end else if (nl && cfg.show_ends) begin
				burst.push_back(tlnv_pkg::CH_DOLLAR);
				burst.push_back(tlnv_pkg::CH_LF);
			end else if (cfg.show_nonprinting && c < tlnv_pkg::CH_CTRL_END &&
					c != tlnv_pkg::CH_LF && c != tlnv_pkg::CH_TAB) begin
				burst.push_back(tlnv_pkg::CH_CARET);
				burst.push_back(c + tlnv_pkg::CARET_OFS);
			end else if (cfg.show_nonprinting && c == tlnv_pkg::CH_DEL) begin
				burst.push_back(tlnv_pkg::CH_CARET);
				burst.push_back(tlnv_pkg::CH_QMARK);
			end else if (cfg.show_nonprinting && c > tlnv_pkg::CH_DEL &&
					c < tlnv_pkg::CH_HIGH_END) begin
				burst.push_back(tlnv_pkg::CH_M);
				burst.push_back(tlnv_pkg::CH_DASH);
				burst.push_back(tlnv_pkg::CH_CARET);
				burst.push_back(c - tlnv_pkg::CARET_OFS);
			end else begin
				burst.push_back(c);
			end

			at_line_start = nl;
			foreach (burst[i])
				expected_q.push_back('{ch: burst[i], last: (i == burst.size() - 1)});
		endfunction

		function void check_output(logic [7:0] ch, logic last);
			rendered_t exp_r;
			if (expected_q.size() == 0) begin
				$error("out_byte %h arrived with nothing expected", ch);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			checked++;
			if (ch !== exp_r.ch) begin
				$error("out_byte: expected %h, got %h", exp_r.ch, ch);
				errors++;
			end
			if (last !== exp_r.last) begin
				$error("last_of_run: expected %b, got %b", exp_r.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     in_byte;
	logic                           new_file;
	logic                           out_valid;
	logic                           out_stall;
	logic [7:0]                     out_byte;
	logic                           last_of_run;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [tlnv_pkg::CFG_IDX_W-1:0] cfg_index;
	logic                           cfg_data;

	filter_scoreboard sb;
	bit               quiet;     // no random gaps on either side while set
	int               phases;

	text_line_number_visible_filter #(.NUMBER_DIGITS(DIGITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.new_file(new_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver back-pressure: alternating runs, mostly short stalls
	initial begin
		int  run_left;
		bit  stalled;
		out_stall = 1'b0;
		run_left  = 0;
		stalled   = 1'b0;
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				stalled = !stalled && ($urandom_range(0, 2) != 0);
				if (!stalled)
					run_left = $urandom_range(1, 30);
				else if ($urandom_range(0, 99) < 70)
					run_left = $urandom_range(1, 3);
				else if ($urandom_range(0, 99) < 85)
					run_left = $urandom_range(4, 10);
				else
					run_left = $urandom_range(20, 60);
			end
			run_left--;
			out_stall <= stalled && !quiet;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_output(out_byte, last_of_run);

	always @(posedge clk) begin
		int idle_cycles;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_item(input logic [7:0] b, input logic nf);
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte  <= b;
		new_file <= nf;
		do @(posedge clk); while (in_stall);
		sb.note_input(b, nf);
	endtask

	task automatic idle_in(input int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// random sender gap after an item
	task automatic pace();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return;
		if (r < 90)
			idle_in($urandom_range(1, 3));
		else if (r < 97)
			idle_in($urandom_range(4, 10));
		else
			idle_in($urandom_range(20, 40));
	endtask

	task automatic send_paced(input logic [7:0] b, input logic nf);
		send_item(b, nf);
		pace();
	endtask

	task automatic hold_until_drained();
		idle_in(1);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// block must be idle: drained first; squeezed items never enter the queue
	task automatic set_config(input tlnv_pkg::cfg_t c);
		logic [tlnv_pkg::CFG_IDX_W-1:0] idx_list[6];
		logic                           vals[6];
		idx_list = '{tlnv_pkg::CFG_NUMBER_ALL, tlnv_pkg::CFG_NUMBER_NONBLANK,
		             tlnv_pkg::CFG_SQUEEZE_BLANK, tlnv_pkg::CFG_SHOW_ENDS,
		             tlnv_pkg::CFG_SHOW_TABS, tlnv_pkg::CFG_SHOW_NONPRINT};
		vals     = '{c.number_all, c.number_nonblank, c.squeeze_blank,
		             c.show_ends, c.show_tabs, c.show_nonprinting};
		hold_until_drained();
		repeat (TAIL) @(posedge clk);
		for (int i = 0; i < 6; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.write_reg(idx_list[i], vals[i]);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		phases++;
	endtask

	// mostly printable text with line ends, some tabs, controls and high bytes
	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 8'($urandom_range(32, 126));
		if (r < 72) return tlnv_pkg::CH_LF;
		if (r < 78) return tlnv_pkg::CH_TAB;
		if (r < 86) return 8'($urandom_range(0, 31));
		if (r < 90) return tlnv_pkg::CH_DEL;
		if (r < 95) return 8'($urandom_range(128, 159));
		return 8'($urandom_range(160, 255));
	endfunction

	task automatic random_phase(input tlnv_pkg::cfg_t c);
		int r, n, hold_at;
		set_config(c);
		hold_at = $urandom_range(8, RAND_ITEMS - 8);
		n = 0;
		while (n < RAND_ITEMS) begin
			if (n == hold_at)
				hold_until_drained();
			r = $urandom_range(0, 99);
			if (r < 8) begin
				// run of blank lines
				repeat ($urandom_range(2, 4)) begin
					send_paced(tlnv_pkg::CH_LF, $urandom_range(0, 9) == 0);
					n++;
				end
			end else if (r < 18) begin
				send_paced(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				n++;
			end else begin
				send_paced(text_byte(), $urandom_range(0, 24) == 0);
				n++;
			end
		end
	endtask

	initial begin
		sb        = new();
		quiet     = 1'b0;
		phases    = 0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_byte   = '0;
		new_file  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// plain pass-through: tab, newline, controls and high bytes unchanged
		set_config('0);
		send_paced(tlnv_pkg::CH_TAB, 1'b1);
		send_paced(8'h00, 1'b0);
		send_paced(tlnv_pkg::CH_DEL, 1'b0);
		send_paced(8'h80, 1'b0);
		send_paced(8'hFF, 1'b0);
		send_paced(tlnv_pkg::CH_LF, 1'b0);

		// everything on: nonblank numbering wins, squeeze, new file mid-run
		set_config('1);
		send_paced(8'h78, 1'b0);
		send_paced(tlnv_pkg::CH_LF, 1'b0);
		send_paced(tlnv_pkg::CH_LF, 1'b0);
		send_paced(tlnv_pkg::CH_LF, 1'b0);
		send_paced(tlnv_pkg::CH_LF, 1'b0);
		send_paced(tlnv_pkg::CH_LF, 1'b1);
		send_paced(tlnv_pkg::CH_TAB, 1'b0);
		send_paced(8'h00, 1'b0);
		send_paced(8'h1F, 1'b0);
		send_paced(tlnv_pkg::CH_DEL, 1'b0);
		send_paced(8'h80, 1'b0);
		send_paced(8'h9F, 1'b0);
		send_paced(8'hA0, 1'b0);
		send_paced(8'hFF, 1'b0);
		send_paced(tlnv_pkg::CH_LF, 1'b0);

		// number every line, blank ones too; ends and tabs shown on their own
		set_config('{number_all: 1'b1, show_ends: 1'b1, show_tabs: 1'b1, default: 1'b0});
		send_paced(tlnv_pkg::CH_LF, 1'b0);
		send_paced(tlnv_pkg::CH_TAB, 1'b0);
		send_paced(tlnv_pkg::CH_LF, 1'b0);
		send_paced(8'h7A, 1'b0);

		quiet = 1'b1;
		random_phase('1);
		quiet = 1'b0;
		random_phase('0);
		for (int p = 0; p < 6; p++) begin
			quiet = (p == 3);
			random_phase(tlnv_pkg::cfg_t'($urandom_range(0, 63)));
		end
		quiet = 1'b0;

		hold_until_drained();
		repeat (TAIL) @(posedge clk);

		$display("Sent %0d text bytes over %0d filter settings; %0d output bytes checked,",
			sb.accepted, phases, sb.checked);
		$display("%0d lines numbered and %0d blank lines squeezed.", sb.numbered, sb.squeezed);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
